// ----- rtl/core/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/ftcp_pkg.sv -----
package ftcp_pkg;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_TYPE    = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // command name, first character at index 0
    localparam logic [3:0][7:0] CMD_NAME = {8'h48, 8'h54, 8'h43, 8'h50};
    localparam logic [2:0] CMD_LEN = 3'd4;

    localparam logic [15:0] LOW_RESET  = 16'd35;
    localparam logic [15:0] HIGH_RESET = 16'd60;

    typedef struct packed {
        logic [15:0] min_threshold;
        logic [15:0] max_threshold;
        logic        frame_done;
        logic        thresholds_updated;
    } t_result;

endpackage

// ----- rtl/core/framed_threshold_command_parser_unit.sv -----
// an accepted word goes from the input register through the parser update into the result register
// throughput: one word per cycle, sustained while the output side keeps taking words
// the rate is set by the parser update between the input and result registers
// reset: synchronous active-low; parser goes to waiting for '$', thresholds to 35 and 60,
// both valid flags cleared; data registers keep whatever they held
module framed_threshold_command_parser_unit #(
    parameter int TYPE_MAX    = 5,
    parameter int PAYLOAD_MAX = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] min_threshold, [31:16] max_threshold
    output logic        m_axis_tlast,   // frame_done
    output logic        m_axis_tuser    // thresholds_updated
);

    // input register stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // result register stage
    logic              r_out_valid;
    ftcp_pkg::t_result r_out;

    ftcp_pkg::t_result parse_result;
    logic              out_load;
    logic              step;

    // result register can take a word when empty or draining this cycle
    assign out_load = !r_out_valid || m_axis_tready;
    // parser advances exactly when the buffered word moves into the result register
    assign step     = r_in_valid && out_load;
    // input register frees up when empty or when its word moves on
    assign s_axis_tready = !r_in_valid || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // frame state, number accumulation and threshold update
    ftcp_parser #(
        .TYPE_MAX    (TYPE_MAX),
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= parse_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.max_threshold, r_out.min_threshold};
    assign m_axis_tlast  = r_out.frame_done;
    assign m_axis_tuser  = r_out.thresholds_updated;

    `include "assert_macros.svh"

    // an update only ever happens on the byte that closes a frame
    `ASSERT_SAME(a_update_closes_frame, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    // thresholds stay ordered from reset through every update
    `ASSERT_SAME(a_thresholds_ordered, i_clk, i_rst_n,
        m_axis_tvalid, $signed(m_axis_tdata[15:0]) < $signed(m_axis_tdata[31:16]))
    // input side only stalls when both stages are full and the output is held
    `ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n,
        !s_axis_tready, r_in_valid && r_out_valid && !m_axis_tready)
    // a buffered word reaches the result register once the output drains
    `ASSERT_NEXT(a_word_advances, i_clk, i_rst_n,
        r_in_valid && out_load, r_out_valid)

endmodule

// ----- rtl/core/ftcp_parser.sv -----
module ftcp_parser #(
    parameter int TYPE_MAX    = 5,
    parameter int PAYLOAD_MAX = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output ftcp_pkg::t_result o_result
);

    localparam logic [2:0] TypeMax    = 3'(TYPE_MAX);
    localparam logic [3:0] PayloadMax = 4'(PAYLOAD_MAX);

    ftcp_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_type_count, n_type_count;
    logic        r_type_match, n_type_match;
    logic [3:0]  r_payload_count, n_payload_count;
    logic [1:0]  r_field_num, n_field_num;
    logic        r_field_start, n_field_start;
    logic        r_first_neg, n_first_neg;
    logic        r_second_neg, n_second_neg;
    logic [15:0] r_first_val, n_first_val;
    logic [15:0] r_second_val, n_second_val;
    logic [15:0] r_low, n_low;
    logic [15:0] r_high, n_high;
    logic        frame_done;
    logic        updated;
    logic [15:0] first_signed;
    logic [15:0] second_signed;

    // value * 10 + (signed char - '0'), wrapping at 16 bits
    function automatic logic [15:0] f_accum(logic [15:0] acc, logic [7:0] b);
        logic [15:0] ext;
        ext = {{8{b[7]}}, b};
        return {acc[12:0], 3'b000} + {acc[14:0], 1'b0} + ext - {8'h00, ftcp_pkg::CH_ZERO};
    endfunction

    assign first_signed  = r_first_neg  ? (16'd0 - r_first_val)  : r_first_val;
    assign second_signed = r_second_neg ? (16'd0 - r_second_val) : r_second_val;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            ftcp_pkg::PH_WAIT: begin
                if (i_byte == ftcp_pkg::CH_DOLLAR) n_phase = ftcp_pkg::PH_TYPE;
            end
            ftcp_pkg::PH_TYPE: begin
                if (i_byte == ftcp_pkg::CH_COMMA) n_phase = ftcp_pkg::PH_PAYLOAD;
                else if (r_type_count >= TypeMax) n_phase = ftcp_pkg::PH_WAIT;
                else if (i_byte == ftcp_pkg::CH_STAR) n_phase = ftcp_pkg::PH_WAIT;
            end
            ftcp_pkg::PH_PAYLOAD: begin
                if (i_byte == ftcp_pkg::CH_STAR) n_phase = ftcp_pkg::PH_WAIT;
                else if (r_payload_count >= PayloadMax) n_phase = ftcp_pkg::PH_WAIT;
            end
            default: n_phase = ftcp_pkg::PH_WAIT;
        endcase
    end

    // field updates and per-byte flags
    always_comb begin
        n_type_count    = r_type_count;
        n_type_match    = r_type_match;
        n_payload_count = r_payload_count;
        n_field_num     = r_field_num;
        n_field_start   = r_field_start;
        n_first_neg     = r_first_neg;
        n_second_neg    = r_second_neg;
        n_first_val     = r_first_val;
        n_second_val    = r_second_val;
        n_low           = r_low;
        n_high          = r_high;
        frame_done      = 1'b0;
        updated         = 1'b0;
        unique case (r_phase)
            ftcp_pkg::PH_WAIT: begin
                if (i_byte == ftcp_pkg::CH_DOLLAR) begin
                    n_type_count = 3'd0;
                    n_type_match = 1'b1;
                end
            end
            ftcp_pkg::PH_TYPE: begin
                if (i_byte == ftcp_pkg::CH_COMMA) begin
                    n_type_match    = r_type_match && (r_type_count == ftcp_pkg::CMD_LEN);
                    n_payload_count = 4'd0;
                    n_field_num     = 2'd0;
                    n_field_start   = 1'b1;
                    n_first_neg     = 1'b0;
                    n_second_neg    = 1'b0;
                    n_first_val     = 16'd0;
                    n_second_val    = 16'd0;
                end else if (r_type_count >= TypeMax) begin
                    n_type_count = 3'd0;
                end else if (i_byte == ftcp_pkg::CH_STAR) begin
                    // empty payload reads as zero and zero, never an update
                    frame_done = 1'b1;
                end else begin
                    n_type_match = r_type_match && (r_type_count < ftcp_pkg::CMD_LEN)
                                   && (i_byte == ftcp_pkg::CMD_NAME[r_type_count[1:0]]);
                    n_type_count = r_type_count + 3'd1;
                end
            end
            ftcp_pkg::PH_PAYLOAD: begin
                if (i_byte == ftcp_pkg::CH_STAR) begin
                    frame_done = 1'b1;
                    if (r_type_match && ($signed(first_signed) < $signed(second_signed))) begin
                        n_low   = first_signed;
                        n_high  = second_signed;
                        updated = 1'b1;
                    end
                end else if (r_payload_count >= PayloadMax) begin
                    n_payload_count = 4'd0;
                end else begin
                    n_payload_count = r_payload_count + 4'd1;
                    if (i_byte == ftcp_pkg::CH_COMMA) begin
                        if (r_field_num < 2'd2) n_field_num = r_field_num + 2'd1;
                        n_field_start = 1'b1;
                    end else if (r_field_num < 2'd2) begin
                        n_field_start = 1'b0;
                        if (r_field_start && (i_byte == ftcp_pkg::CH_MINUS)) begin
                            if (r_field_num == 2'd0) n_first_neg = 1'b1;
                            else n_second_neg = 1'b1;
                        end else if (!(r_field_start && (i_byte == ftcp_pkg::CH_PLUS))) begin
                            if (r_field_num == 2'd0) n_first_val = f_accum(r_first_val, i_byte);
                            else n_second_val = f_accum(r_second_val, i_byte);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= ftcp_pkg::PH_WAIT;
            r_type_count    <= 3'd0;
            r_type_match    <= 1'b0;
            r_payload_count <= 4'd0;
            r_field_num     <= 2'd0;
            r_field_start   <= 1'b1;
            r_first_neg     <= 1'b0;
            r_second_neg    <= 1'b0;
            r_first_val     <= 16'd0;
            r_second_val    <= 16'd0;
            r_low           <= ftcp_pkg::LOW_RESET;
            r_high          <= ftcp_pkg::HIGH_RESET;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_type_count    <= n_type_count;
            r_type_match    <= n_type_match;
            r_payload_count <= n_payload_count;
            r_field_num     <= n_field_num;
            r_field_start   <= n_field_start;
            r_first_neg     <= n_first_neg;
            r_second_neg    <= n_second_neg;
            r_first_val     <= n_first_val;
            r_second_val    <= n_second_val;
            r_low           <= n_low;
            r_high          <= n_high;
        end
    end

    assign o_result.min_threshold      = n_low;
    assign o_result.max_threshold      = n_high;
    assign o_result.frame_done         = frame_done;
    assign o_result.thresholds_updated = updated;

endmodule

// ----- test/framed_threshold_command_parser_unit_test.sv -----
module framed_threshold_command_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TYPE_MAX      = 5;
    localparam int PAYLOAD_MAX   = 10;
    localparam int BYTE_TARGET   = 850;     // total bytes to send, directed ones included
    localparam int HOLD_CYCLES   = 200;     // long output back-pressure stretch
    localparam int CYCLE_LIMIT   = 500000;  // run watchdog
    localparam int SETTLE_CYCLES = 8;

    // tracks parser state and the thresholds, holds one expected result per word
    class t_threshold_board;
        ftcp_pkg::t_phase  phase;
        logic [2:0]        type_count;
        bit                type_ok;
        logic [3:0]        payload_count;
        logic [1:0]        field_no;
        bit                field_start;
        bit                first_neg;
        bit                second_neg;
        logic [15:0]       first_val;
        logic [15:0]       second_val;
        logic [15:0]       low_limit;
        logic [15:0]       high_limit;
        ftcp_pkg::t_result pending[$];
        int                errors;

        function new();
            phase         = ftcp_pkg::PH_WAIT;
            type_count    = '0;
            type_ok       = 1'b0;
            payload_count = '0;
            field_no      = '0;
            field_start   = 1'b1;
            first_neg     = 1'b0;
            second_neg    = 1'b0;
            first_val     = '0;
            second_val    = '0;
            low_limit     = ftcp_pkg::LOW_RESET;
            high_limit    = ftcp_pkg::HIGH_RESET;
            errors        = 0;
        endfunction

        // advance the parser by one received byte and queue the word it must produce
        function void note_byte(logic [7:0] b);
            ftcp_pkg::t_result r;
            bit                done;
            bit                updated;
            bit                skip;
            logic [15:0]       digit;
            logic [15:0]       lo;
            logic [15:0]       hi;
            done    = 1'b0;
            updated = 1'b0;
            case (phase)
                ftcp_pkg::PH_WAIT: begin
                    if (b == ftcp_pkg::CH_DOLLAR) begin
                        phase      = ftcp_pkg::PH_TYPE;
                        type_count = '0;
                        type_ok    = 1'b1;
                    end
                end
                ftcp_pkg::PH_TYPE: begin
                    if (b == ftcp_pkg::CH_COMMA) begin
                        type_ok       = type_ok && (type_count == ftcp_pkg::CMD_LEN);
                        phase         = ftcp_pkg::PH_PAYLOAD;
                        payload_count = '0;
                        field_no      = '0;
                        field_start   = 1'b1;
                        first_neg     = 1'b0;
                        second_neg    = 1'b0;
                        first_val     = '0;
                        second_val    = '0;
                    end else if (type_count >= TYPE_MAX) begin
                        // over-long type, frame dropped
                        phase      = ftcp_pkg::PH_WAIT;
                        type_count = '0;
                    end else if (b == ftcp_pkg::CH_STAR) begin
                        // frame without payload: values are 0 and 0, never an update
                        phase = ftcp_pkg::PH_WAIT;
                        done  = 1'b1;
                    end else begin
                        type_ok    = type_ok && (type_count < ftcp_pkg::CMD_LEN) &&
                                     (b == ftcp_pkg::CMD_NAME[type_count[1:0]]);
                        type_count = type_count + 3'd1;
                    end
                end
                ftcp_pkg::PH_PAYLOAD: begin
                    if (b == ftcp_pkg::CH_STAR) begin
                        phase = ftcp_pkg::PH_WAIT;
                        done  = 1'b1;
                        if (type_ok) begin
                            lo = first_neg  ? (16'd0 - first_val)  : first_val;
                            hi = second_neg ? (16'd0 - second_val) : second_val;
                            if ($signed(lo) < $signed(hi)) begin
                                low_limit  = lo;
                                high_limit = hi;
                                updated    = 1'b1;
                            end
                        end
                    end else if (payload_count >= PAYLOAD_MAX) begin
                        // payload too long, byte and frame dropped
                        phase         = ftcp_pkg::PH_WAIT;
                        payload_count = '0;
                    end else begin
                        if (b == ftcp_pkg::CH_COMMA) begin
                            if (field_no < 2'd2) field_no = field_no + 2'd1;
                            field_start = 1'b1;
                        end else if (field_no < 2'd2) begin
                            skip = 1'b0;
                            if (field_start) begin
                                field_start = 1'b0;
                                if (b == ftcp_pkg::CH_MINUS) begin
                                    if (field_no == 2'd0) first_neg = 1'b1;
                                    else second_neg = 1'b1;
                                    skip = 1'b1;
                                end else if (b == ftcp_pkg::CH_PLUS) begin
                                    skip = 1'b1;
                                end
                            end
                            if (!skip) begin
                                // any byte counts as a digit, read as signed char
                                digit = {{8{b[7]}}, b} - {8'd0, ftcp_pkg::CH_ZERO};
                                if (field_no == 2'd0) first_val = first_val * 16'd10 + digit;
                                else second_val = second_val * 16'd10 + digit;
                            end
                        end
                        payload_count = payload_count + 4'd1;
                    end
                end
                default: phase = ftcp_pkg::PH_WAIT;
            endcase
            r.min_threshold      = low_limit;
            r.max_threshold      = high_limit;
            r.frame_done         = done;
            r.thresholds_updated = updated;
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [31:0] data, logic last, logic user);
            ftcp_pkg::t_result e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word data=%h last=%b user=%b", data, last, user));
                return;
            end
            e = pending.pop_front();
            if (data[15:0] !== e.min_threshold)
                report($sformatf("min_threshold got %0d want %0d",
                                 $signed(data[15:0]), $signed(e.min_threshold)));
            if (data[31:16] !== e.max_threshold)
                report($sformatf("max_threshold got %0d want %0d",
                                 $signed(data[31:16]), $signed(e.max_threshold)));
            if (last !== e.frame_done)
                report($sformatf("frame_done got %b want %b", last, e.frame_done));
            if (user !== e.thresholds_updated)
                report($sformatf("thresholds_updated got %b want %b",
                                 user, e.thresholds_updated));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;      // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;             // [15:0] min_threshold, [31:16] max_threshold
    logic        m_axis_tlast;             // frame_done
    logic        m_axis_tuser;             // thresholds_updated

    t_threshold_board board = new();
    logic [7:0]       line_q[$];           // bytes of the frame being built
    int               bytes_sent = 0;
    int               cycle_count = 0;
    bit               quiet = 1'b0;        // no idling on either side while set
    bit               hold_request = 1'b0; // asks the output side for a long stall

    framed_threshold_command_parser_unit #(
        .TYPE_MAX   (TYPE_MAX),
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[framed_threshold_command_parser_unit] ERROR");
            $finish;
        end
    end

    // every accepted result word is compared with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // output side: random stalls, plus one long hold when asked
    initial begin : result_side
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // offer one word; valid stays high afterwards so back-to-back words need no dip
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_line();
        while (line_q.size() != 0) send_byte(line_q.pop_front());
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic void push_text(string s);
        foreach (s[i]) line_q.push_back(s[i]);
    endfunction

    // signed decimal field, sometimes with a non-digit thrown in
    function automatic void push_field(int max_digits, bit noisy);
        int n;
        case ($urandom_range(0, 3))
            0: line_q.push_back(ftcp_pkg::CH_MINUS);
            1: line_q.push_back(ftcp_pkg::CH_PLUS);
            default: ;
        endcase
        n = $urandom_range(0, max_digits);
        repeat (n) begin
            if (noisy && $urandom_range(0, 9) == 0)
                line_q.push_back(8'($urandom_range(0, 255)));
            else
                line_q.push_back(ftcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    // type text: often the command name or a near miss, at random lengths
    function automatic void push_type(int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) < 7)
                line_q.push_back(ftcp_pkg::CMD_NAME[i % 4]);
            else if ($urandom_range(0, 3) == 0)
                line_q.push_back(8'($urandom_range(0, 255)));
            else
                line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
    endfunction

    initial begin : stimulus
        int  kind;
        int  n;
        bit  hold_done;
        bit  drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset thresholds, signed fields, empty command, extreme bytes,
        // type of exactly the maximum length, over-long type, missing second field, over-long payload
        line_q.push_back(8'h00);
        push_text("$PCTH,-5,+7*");
        push_text("$PCTH*");
        push_text("$ABCDE,");
        line_q.push_back(8'hFF);
        line_q.push_back(8'h80);
        line_q.push_back(8'h7F);
        push_text("*$PCTHX*");
        push_text("$PCTH,-32768,9*");
        push_text("$PCTH,-3*");
        push_text("$PCTH,1234567890X*");
        send_line();

        while (bytes_sent < BYTE_TARGET) begin
            if ($urandom_range(0, 15) == 0) quiet = !quiet;
            if (!hold_done && bytes_sent >= 300) begin
                // stall the output while words keep coming, so the input backs up
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && bytes_sent >= 600) begin
                // input goes quiet until every result has come out
                s_axis_tvalid <= 1'b0;
                wait_drained();
                drain_done = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                // well-formed threshold command, random values
                push_text("$PCTH,");
                push_field(3, 1'b1);
                if ($urandom_range(0, 7) != 0) begin
                    line_q.push_back(ftcp_pkg::CH_COMMA);
                    push_field(3, 1'b1);
                    if ($urandom_range(0, 9) == 0) begin
                        line_q.push_back(ftcp_pkg::CH_COMMA);
                        push_field(2, 1'b0);
                    end
                end
                line_q.push_back(ftcp_pkg::CH_STAR);
            end else if (kind < 65) begin
                // frame without payload
                line_q.push_back(ftcp_pkg::CH_DOLLAR);
                push_type($urandom_range(0, 6));
                line_q.push_back(ftcp_pkg::CH_STAR);
            end else if (kind < 80) begin
                // other types, some too long, with random payload bytes
                line_q.push_back(ftcp_pkg::CH_DOLLAR);
                push_type($urandom_range(0, 7));
                line_q.push_back(ftcp_pkg::CH_COMMA);
                n = $urandom_range(0, 12);
                repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
                line_q.push_back(ftcp_pkg::CH_STAR);
            end else if (kind < 90) begin
                // line noise between frames
                n = $urandom_range(1, 6);
                repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                // broken command: over-long payload or cut short
                push_text("$PCTH,");
                n = $urandom_range(4, 14);
                repeat (n) line_q.push_back(ftcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 1) == 0) line_q.push_back(ftcp_pkg::CH_STAR);
            end
            send_line();
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("[framed_threshold_command_parser_unit] OK");
        end else begin
            $display("[framed_threshold_command_parser_unit] ERROR");
        end
        $finish;
    end

endmodule

// ----- framed_threshold_command_parser_unit.f -----
+incdir+rtl/core
rtl/core/ftcp_pkg.sv
rtl/core/ftcp_parser.sv
rtl/core/framed_threshold_command_parser_unit.sv
test/framed_threshold_command_parser_unit_test.sv
